>>> hw/rtl/abb_pkg.sv
// Shared types, constants and arithmetic helpers for the ARGB4444 blend blit engine.
package abb_pkg;

  // Largest rectangle side in pixels
  localparam int MAX_DIM = 1024;

  localparam int PosW     = $clog2(MAX_DIM);  // column / line counter width
  localparam int DimW     = 11;               // size and stride register width
  localparam int OrgW     = 10;               // origin register width
  localparam int IdxW     = 21;               // word index width
  localparam int PixW     = 16;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = DimW;

  // Division by 15 as multiply by reciprocal: exact for x below 4681
  localparam int Div15Mul   = 2185;
  localparam int Div15Shift = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RECT_WIDTH  = 4'd0,
    CFG_RECT_HEIGHT = 4'd1,
    CFG_DEST_STRIDE = 4'd2,
    CFG_DEST_LEFT   = 4'd3,
    CFG_DEST_TOP    = 4'd4,
    CFG_SRC_STRIDE  = 4'd5,
    CFG_SRC_LEFT    = 4'd6,
    CFG_SRC_TOP     = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [DimW-1:0] rect_width;
    logic [DimW-1:0] rect_height;
    logic [DimW-1:0] dest_stride;
    logic [OrgW-1:0] dest_left;
    logic [OrgW-1:0] dest_top;
    logic [DimW-1:0] src_stride;
    logic [OrgW-1:0] src_left;
    logic [OrgW-1:0] src_top;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0] src_pixel;
    logic [PixW-1:0] dest_pixel;
  } in_t;

  typedef struct packed {
    logic [PixW-1:0] blended_pixel;
    logic [IdxW-1:0] dest_index;
    logic [IdxW-1:0] src_index;
    logic            last_pixel;
  } out_t;

  // Scan position of one pixel
  typedef struct packed {
    logic [PosW-1:0] col;
    logic [PosW-1:0] line;
    logic            last;
  } pos_t;

  // Zero acts as one, oversize acts as MAX_DIM
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MAX_DIM)) begin
      r = DimW'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Truncating divide by 15 for sums up to 1845
  function automatic logic [6:0] div15(input logic [10:0] x);
    logic [22:0] prod;
    prod = 23'(x) * 23'(Div15Mul);
    return prod[Div15Shift+6:Div15Shift];
  endfunction

endpackage

>>> hw/rtl/argb4444_blend_blit_top.sv
// Top level of the ARGB4444-over-RGB565 blend blit engine.
// Pipeline: input register, then result register.
// Throughput: one pixel per cycle; the input side stalls only while the result is stalled.
// Reset clears both pipeline valids and the scan counters, and loads
// sizes and strides with 1 and origins with 0.
module argb4444_blend_blit_top
  import abb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o
);

  cfg_t cfg;
  pos_t pos;

  logic in_xfer, s2_load;
  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  in_t  s1_data_q;
  pos_t s1_pos_q;
  out_t s2_data_q, s2_data_d;

  logic [PixW-1:0]   blend_pix;
  logic [DimW-1:0]   dest_row, src_row;
  logic [2*DimW:0]   dest_sum, src_sum;

  abb_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  abb_scan_ctr u_scan (
    .clk_i,
    .rst_ni,
    .cfg_i (cfg),
    .adv_i (in_xfer),
    .pos_o (pos)
  );

  // Pipeline flow control
  assign s2_load    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s2_load;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s2_load) begin
      s2_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      s2_valid_d = 1'b0;
    end
  end

  // Result stage: blend and word indices
  abb_blend u_blend (
    .pix_i (s1_data_q),
    .pix_o (blend_pix)
  );

  assign dest_row = DimW'(cfg.dest_top) + DimW'(s1_pos_q.line);
  assign src_row  = DimW'(cfg.src_top) + DimW'(s1_pos_q.line);
  assign dest_sum = (2*DimW+1)'(dest_row) * (2*DimW+1)'(cfg.dest_stride)
                  + (2*DimW+1)'(cfg.dest_left) + (2*DimW+1)'(s1_pos_q.col);
  assign src_sum  = (2*DimW+1)'(src_row) * (2*DimW+1)'(cfg.src_stride)
                  + (2*DimW+1)'(cfg.src_left) + (2*DimW+1)'(s1_pos_q.col);

  always_comb begin
    s2_data_d.blended_pixel = blend_pix;
    s2_data_d.dest_index    = dest_sum[IdxW-1:0];
    s2_data_d.src_index     = src_sum[IdxW-1:0];
    s2_data_d.last_pixel    = s1_pos_q.last;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
      s1_pos_q  <= pos;
    end
    if (s2_load) begin
      s2_data_q <= s2_data_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

`ifndef ASSERT_OFF
  // Input side only stalls while the input register holds a pixel
  a_stall_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // A transferred pixel lands in the input register
  a_xfer_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_valid_q)
    else $error("transferred pixel lost");

  // Both stages full and output stalled: input must stall
  a_full_back_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && out_stall_i) |-> in_stall_o)
    else $error("pipeline overrun");

  // Result register only drops after its transfer
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && out_stall_i) |=> s2_valid_q)
    else $error("stalled result dropped");
`endif

endmodule

>>> hw/rtl/abb_cfg_regs.sv
// Configuration register file of the blend blit engine.
module abb_cfg_regs
  import abb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indices leave everything alone
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_RECT_WIDTH:  cfg_d.rect_width  = cfg_wdata_i;
        CFG_RECT_HEIGHT: cfg_d.rect_height = cfg_wdata_i;
        CFG_DEST_STRIDE: cfg_d.dest_stride = cfg_wdata_i;
        CFG_DEST_LEFT:   cfg_d.dest_left   = cfg_wdata_i[OrgW-1:0];
        CFG_DEST_TOP:    cfg_d.dest_top    = cfg_wdata_i[OrgW-1:0];
        CFG_SRC_STRIDE:  cfg_d.src_stride  = cfg_wdata_i;
        CFG_SRC_LEFT:    cfg_d.src_left    = cfg_wdata_i[OrgW-1:0];
        CFG_SRC_TOP:     cfg_d.src_top     = cfg_wdata_i[OrgW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rect_width  <= DimW'(1);
      cfg_q.rect_height <= DimW'(1);
      cfg_q.dest_stride <= DimW'(1);
      cfg_q.dest_left   <= '0;
      cfg_q.dest_top    <= '0;
      cfg_q.src_stride  <= DimW'(1);
      cfg_q.src_left    <= '0;
      cfg_q.src_top     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/abb_scan_ctr.sv
// Row-major column and line counters over the blit rectangle.
module abb_scan_ctr
  import abb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic adv_i,   // one pixel transferred in
  output pos_t pos_o    // position of the pixel being transferred
);

  logic [PosW-1:0] col_q, col_d;
  logic [PosW-1:0] line_q, line_d;
  logic [DimW-1:0] last_col, last_line;
  logic            col_end, line_end;

  // At or beyond the last column/line counts as at it (size may shrink)
  assign last_col  = clamp_dim(cfg_i.rect_width) - DimW'(1);
  assign last_line = clamp_dim(cfg_i.rect_height) - DimW'(1);
  assign col_end   = DimW'(col_q) >= last_col;
  assign line_end  = DimW'(line_q) >= last_line;

  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    if (adv_i) begin
      if (col_end) begin
        col_d  = '0;
        line_d = line_end ? '0 : line_q + PosW'(1);
      end else begin
        col_d = col_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
    end else begin
      col_q  <= col_d;
      line_q <= line_d;
    end
  end

  assign pos_o.col  = col_q;
  assign pos_o.line = line_q;
  assign pos_o.last = col_end && line_end;

endmodule

>>> hw/rtl/abb_blend.sv
// ARGB4444 over RGB565 per-channel alpha blend, combinational.
module abb_blend
  import abb_pkg::*;
(
  input  in_t             pix_i,
  output logic [PixW-1:0] pix_o
);

  logic [3:0]  alpha, inv_alpha;
  logic [4:0]  src_r, src_b, dst_r, dst_b;
  logic [5:0]  src_g, dst_g;
  logic [10:0] sum_r, sum_g, sum_b;
  logic [6:0]  res_r, res_g, res_b;

  // Unpack; source widened by a plain shift
  assign alpha     = pix_i.src_pixel[15:12];
  assign inv_alpha = 4'hf - alpha;
  assign src_r     = {pix_i.src_pixel[11:8], 1'b0};
  assign src_g     = {pix_i.src_pixel[7:4], 2'b00};
  assign src_b     = {pix_i.src_pixel[3:0], 1'b0};
  assign dst_r     = pix_i.dest_pixel[15:11];
  assign dst_g     = pix_i.dest_pixel[10:5];
  assign dst_b     = pix_i.dest_pixel[4:0];

  // Weighted sums, then truncating divide by 15
  assign sum_r = 11'(src_r) * 11'(alpha) + 11'(dst_r) * 11'(inv_alpha);
  assign sum_g = 11'(src_g) * 11'(alpha) + 11'(dst_g) * 11'(inv_alpha);
  assign sum_b = 11'(src_b) * 11'(alpha) + 11'(dst_b) * 11'(inv_alpha);

  assign res_r = div15(sum_r);
  assign res_g = div15(sum_g);
  assign res_b = div15(sum_b);

  assign pix_o = {res_r[4:0], res_g[5:0], res_b[4:0]};

endmodule

>>> test/tb_argb4444_blend_blit_top.sv
// Self-checking testbench for the ARGB4444-over-RGB565 blend blit engine.
module tb_argb4444_blend_blit_top;
  timeunit 1ns;
  timeprecision 1ps;
  import abb_pkg::*;

  // Config indexes past the last register; the block must ignore them
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 4'd9;
  localparam logic [CfgIdxW-1:0] CfgIdxTop   = 4'd15;
  localparam int RandPixels = 2000;

  // One row of the directed table: a register write or a pixel pair,
  // optionally with the result typed in
  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] wdata;
    in_t                 px;
    logic                typed;
    out_t                want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;

  // Shadow of the register file and scan position
  logic [DimW-1:0] width_reg, height_reg, dst_stride_reg, src_stride_reg;
  logic [OrgW-1:0] dst_left_reg, dst_top_reg, src_left_reg, src_top_reg;
  int unsigned     scan_col, scan_line;

  out_t expected_px[$];
  row_t dir_tab[$];
  int   mismatch_cnt = 0;
  int   burst_left = 0;

  argb4444_blend_blit_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Register write as seen by the predictor, masked to register width
  function automatic void shadow_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      CFG_RECT_WIDTH:  width_reg = val;
      CFG_RECT_HEIGHT: height_reg = val;
      CFG_DEST_STRIDE: dst_stride_reg = val;
      CFG_DEST_LEFT:   dst_left_reg = val[OrgW-1:0];
      CFG_DEST_TOP:    dst_top_reg = val[OrgW-1:0];
      CFG_SRC_STRIDE:  src_stride_reg = val;
      CFG_SRC_LEFT:    src_left_reg = val[OrgW-1:0];
      CFG_SRC_TOP:     src_top_reg = val[OrgW-1:0];
      default: ;
    endcase
  endfunction

  // Effective side length: zero acts as one, oversize saturates
  function automatic int unsigned eff_size(logic [DimW-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned blend_chan(int unsigned wide_src, int unsigned dst,
                                             int unsigned alpha);
    return (wide_src * alpha + dst * (15 - alpha)) / 15;
  endfunction

  // Blend one pixel pair, compute word indices and advance the scan
  function automatic out_t predict_blend(in_t px);
    int unsigned alpha, r, g, b, w, h, didx, sidx;
    out_t o;
    alpha = px.src_pixel[15:12];
    r = blend_chan({px.src_pixel[11:8], 1'b0}, px.dest_pixel[15:11], alpha);
    g = blend_chan({px.src_pixel[7:4], 2'b00}, px.dest_pixel[10:5], alpha);
    b = blend_chan({px.src_pixel[3:0], 1'b0}, px.dest_pixel[4:0], alpha);
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    didx = (dst_top_reg + scan_line) * dst_stride_reg + dst_left_reg + scan_col;
    sidx = (src_top_reg + scan_line) * src_stride_reg + src_left_reg + scan_col;
    o.blended_pixel = {r[4:0], g[5:0], b[4:0]};
    o.dest_index = didx[IdxW-1:0];
    o.src_index = sidx[IdxW-1:0];
    o.last_pixel = 1'b0;
    if (scan_col >= w - 1) begin
      scan_col = 0;
      if (scan_line >= h - 1) begin
        scan_line = 0;
        o.last_pixel = 1'b1;
      end else begin
        scan_line++;
      end
    end else begin
      scan_col++;
    end
    return o;
  endfunction

  // Sender gap: mostly none, some short, a few long; gapless bursts now and then
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) burst_left = $urandom_range(20, 80);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_cfg_value(cfg_reg_e r);
    int sel;
    sel = $urandom_range(0, 99);
    case (r)
      CFG_RECT_WIDTH, CFG_RECT_HEIGHT: begin
        if (sel < 85) return CfgDataW'($urandom_range(1, 8));
        if (sel < 88) return '0;
        if (sel < 91) return CfgDataW'(MAX_DIM);
        if (sel < 94) return CfgDataW'(MAX_DIM + 1);
        if (sel < 97) return '1;
        return CfgDataW'($urandom_range(0, 2047));
      end
      CFG_DEST_STRIDE, CFG_SRC_STRIDE: begin
        if (sel < 50) return CfgDataW'($urandom_range(1, 64));
        if (sel < 57) return '0;
        if (sel < 64) return '1;
        if (sel < 70) return CfgDataW'(MAX_DIM);
        return CfgDataW'($urandom_range(0, 2047));
      end
      default: begin
        if (sel < 30) return CfgDataW'($urandom_range(0, 15));
        if (sel < 40) return '0;
        if (sel < 50) return '1;
        if (sel < 55) return CfgDataW'(1023);
        return CfgDataW'($urandom_range(0, 2047));
      end
    endcase
  endfunction

  function automatic in_t pick_pixel();
    in_t px;
    int sel;
    px = {16'($urandom), 16'($urandom)};
    sel = $urandom_range(0, 99);
    if (sel < 20) px.src_pixel[15:12] = 4'h0;
    else if (sel < 40) px.src_pixel[15:12] = 4'hF;
    return px;
  endfunction

  function automatic row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    return {1'b1, idx, val, in_t'('0), 1'b0, out_t'('0)};
  endfunction

  function automatic row_t px_row(logic [PixW-1:0] src, logic [PixW-1:0] dst);
    return {1'b0, {CfgIdxW{1'b0}}, {CfgDataW{1'b0}}, src, dst, 1'b0, out_t'('0)};
  endfunction

  function automatic row_t px_known(logic [PixW-1:0] src, logic [PixW-1:0] dst, out_t want);
    return {1'b0, {CfgIdxW{1'b0}}, {CfgDataW{1'b0}}, src, dst, 1'b1, want};
  endfunction

  // Drive one register write; called at a falling edge, returns at the next
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    shadow_write(idx, val);
    @(negedge clk);
  endtask

  // Hold the input side off until every pending result has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_px.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Offer one pixel pair, wait for the transfer, queue its expected result
  task automatic push_pixel(in_t px, logic typed, out_t want);
    int gap;
    out_t exp_px;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_px = predict_blend(px);
    expected_px.push_back(typed ? want : exp_px);
    @(negedge clk);
  endtask

  // Output stall: stretches of free flow, short and occasional long stalls
  initial begin
    int r, run;
    logic level;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        level = 1'b0;
        run = $urandom_range(40, 120);
      end else if (r < 55) begin
        level = 1'b0;
        run = $urandom_range(1, 6);
      end else if (r < 93) begin
        level = 1'b1;
        run = $urandom_range(1, 3);
      end else begin
        level = 1'b1;
        run = $urandom_range(8, 40);
      end
      repeat (run) begin
        @(negedge clk);
        out_stall <= level;
      end
    end
  end

  // Result checker: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_px.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: pix %h didx %h sidx %h last %b",
                   out_data.blended_pixel, out_data.dest_index, out_data.src_index,
                   out_data.last_pixel);
      end else begin
        want = expected_px.pop_front();
        if (want.blended_pixel !== out_data.blended_pixel ||
            want.dest_index !== out_data.dest_index ||
            want.src_index !== out_data.src_index ||
            want.last_pixel !== out_data.last_pixel) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp pix %h didx %h sidx %h last %b, got %h %h %h %b",
                     want.blended_pixel, want.dest_index, want.src_index, want.last_pixel,
                     out_data.blended_pixel, out_data.dest_index, out_data.src_index,
                     out_data.last_pixel);
        end
      end
    end
  end

  // Run limit
  initial begin
    #10ms;
    $display("tb_argb4444_blend_blit_top: done, errors");
    $finish;
  end

  initial begin
    logic prev_cfg;
    int   rand_sent;
    int   n;
    width_reg = 1;
    height_reg = 1;
    dst_stride_reg = 1;
    src_stride_reg = 1;
    dst_left_reg = '0;
    dst_top_reg = '0;
    src_left_reg = '0;
    src_top_reg = '0;
    scan_col = 0;
    scan_line = 0;

    // Values after reset: full alpha, zero alpha, white-as-30 expansion
    dir_tab.push_back(px_known(16'h0000, 16'hFFFF, {16'hFFFF, 21'd0, 21'd0, 1'b1}));
    dir_tab.push_back(px_known(16'hFFFF, 16'h0000, {16'hF79E, 21'd0, 21'd0, 1'b1}));
    dir_tab.push_back(px_known(16'hF000, 16'hFFFF, {16'h0000, 21'd0, 21'd0, 1'b1}));
    dir_tab.push_back(px_known(16'h0FFF, 16'hFFFF, {16'hFFFF, 21'd0, 21'd0, 1'b1}));
    dir_tab.push_back(px_row(16'h7A5C, 16'h1234));
    // Zero size acts as one
    dir_tab.push_back(cfg_row(CFG_RECT_WIDTH, '0));
    dir_tab.push_back(cfg_row(CFG_RECT_HEIGHT, '0));
    dir_tab.push_back(px_row(16'h5555, 16'hAAAA));
    // Writes past the last register are dropped
    dir_tab.push_back(cfg_row(CfgIdxSpare, 11'd7));
    dir_tab.push_back(cfg_row(CfgIdxTop, '1));
    dir_tab.push_back(px_row(16'hAAAA, 16'h5555));
    // Oversize rectangle, zero stride, origin masked to 10 bits
    dir_tab.push_back(cfg_row(CFG_RECT_WIDTH, '1));
    dir_tab.push_back(cfg_row(CFG_RECT_HEIGHT, '1));
    dir_tab.push_back(cfg_row(CFG_DEST_STRIDE, '0));
    dir_tab.push_back(cfg_row(CFG_DEST_LEFT, '1));
    dir_tab.push_back(cfg_row(CFG_SRC_STRIDE, 11'd1024));
    dir_tab.push_back(cfg_row(CFG_SRC_LEFT, 11'd5));
    dir_tab.push_back(cfg_row(CFG_SRC_TOP, 11'd3));
    dir_tab.push_back(px_row(16'h8000, 16'hFFFF));
    dir_tab.push_back(px_row(16'h1FFF, 16'h0000));
    dir_tab.push_back(px_row(16'hF0F0, 16'h07E0));
    // Shrink while the column counter sits past the new edge
    dir_tab.push_back(cfg_row(CFG_RECT_WIDTH, 11'd2));
    dir_tab.push_back(cfg_row(CFG_RECT_HEIGHT, 11'd2));
    dir_tab.push_back(px_row(16'h3C3C, 16'hF800));
    dir_tab.push_back(px_row(16'hC0F0, 16'h001F));
    dir_tab.push_back(px_row(16'h9ABC, 16'hDEF0));
    // Index overflow: the last pixel lands exactly on 2^21
    dir_tab.push_back(cfg_row(CFG_DEST_STRIDE, '1));
    dir_tab.push_back(cfg_row(CFG_DEST_TOP, 11'd1023));
    dir_tab.push_back(cfg_row(CFG_DEST_LEFT, 11'd1023));
    dir_tab.push_back(cfg_row(CFG_SRC_STRIDE, '1));
    dir_tab.push_back(cfg_row(CFG_SRC_TOP, 11'd1023));
    dir_tab.push_back(cfg_row(CFG_SRC_LEFT, 11'd1023));
    dir_tab.push_back(px_row(16'h6E6E, 16'h4208));
    dir_tab.push_back(px_row(16'hE123, 16'hBDEF));
    dir_tab.push_back(px_row(16'h2F00, 16'h7BEF));
    dir_tab.push_back(px_known(16'h0000, 16'h0000, {16'h0000, 21'd0, 21'd0, 1'b1}));

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    prev_cfg = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (!prev_cfg) wait_idle();
        cfg_write(dir_tab[i].reg_idx, dir_tab[i].wdata);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_we <= 1'b0;
        prev_cfg = 1'b0;
        push_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random phases: drain, reprogram some registers, then stream pixels
    rand_sent = 0;
    while (rand_sent < RandPixels) begin
      wait_idle();
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 1))
          cfg_write(cfg_reg_e'(k), pick_cfg_value(cfg_reg_e'(k)));
      end
      if ($urandom_range(0, 9) == 0)
        cfg_write(CfgDataW'($urandom_range(0, 1)) ? CfgIdxTop : CfgIdxSpare,
                  CfgDataW'($urandom_range(0, 2047)));
      cfg_we <= 1'b0;
      n = $urandom_range(20, 160);
      repeat (n) push_pixel(pick_pixel(), 1'b0, out_t'('0));
      rand_sent += n;
    end
    in_valid <= 1'b0;

    while (expected_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && expected_px.size() == 0) begin
      $display("tb_argb4444_blend_blit_top: done, clean");
    end else begin
      $display("tb_argb4444_blend_blit_top: done, errors");
    end
    $finish;
  end

endmodule
